// ===== hdl/sfc_pkg.sv =====
// shared constants, codes and types of the stereo fir convolver
package sfc_pkg;

  localparam int MAX_TAPS_DEF = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int TAP_IDX_W  = 10;
  localparam int TIU_W      = 11;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // q2.30 sum times q4.12 gain back to q1.15
  localparam int ROUND_SH = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  localparam logic [TIU_W-1:0]  TIU_RESET  = 11'd1024;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

  typedef struct packed {
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

// ===== hdl/sfc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module sfc_ram #(
  parameter int WIDTH = sfc_pkg::SAMPLE_W,
  parameter int DEPTH = sfc_pkg::MAX_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sfc_mac.sv =====
// registered multiply and accumulate for one output channel
module sfc_mac #(
  parameter int ACC_W = 2 * sfc_pkg::SAMPLE_W + $clog2(sfc_pkg::MAX_TAPS_DEF)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  sfc_pkg::mac_ctl_t                  ctl,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0] x,
  input  logic signed [sfc_pkg::COEF_W-1:0]   tap,
  output logic signed [ACC_W-1:0]            acc,
  output logic                               done
);

  localparam int PROD_W = sfc_pkg::SAMPLE_W + sfc_pkg::COEF_W;

  sfc_pkg::mac_ctl_t        p2;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2   <= '0;
      done <= 1'b0;
    end else begin
      p2   <= ctl;
      done <= p2.valid && p2.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= x * tap;
    if (clear) begin
      acc <= '0;
    end else if (p2.valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ===== hdl/sfc_scale.sv =====
// gain scaling in two partial products, round half up and saturate
module sfc_scale #(
  parameter int ACC_W = 2 * sfc_pkg::SAMPLE_W + $clog2(sfc_pkg::MAX_TAPS_DEF)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ACC_W-1:0]             acc,
  input  logic [sfc_pkg::GAIN_W-1:0]          gain,
  output logic signed [sfc_pkg::SAMPLE_W-1:0] res,
  output logic                                done
);

  localparam int GW   = sfc_pkg::GAIN_W;
  localparam int LO_W = ACC_W / 2;
  localparam int HI_W = ACC_W - LO_W;
  localparam int V_W  = ACC_W + GW + 2;
  localparam int RS_W = V_W - sfc_pkg::ROUND_SH;
  localparam logic signed [RS_W-1:0] SAT_HI = RS_W'(sfc_pkg::OUT_MAX);
  localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(sfc_pkg::OUT_MIN);

  logic                          v1;
  logic                          v2;
  logic [LO_W+GW-1:0]            plo;
  logic signed [HI_W+GW:0]       phi;
  logic signed [V_W-1:0]         vsum;
  logic signed [RS_W-1:0]        rsh;
  logic signed [sfc_pkg::SAMPLE_W-1:0] sat;

  assign vsum = (V_W'(phi) <<< LO_W) + $signed(V_W'(plo))
              + (V_W'(1) <<< (sfc_pkg::ROUND_SH - 1));

  always_comb begin
    if (rsh > SAT_HI) begin
      sat = sfc_pkg::OUT_MAX;
    end else if (rsh < SAT_LO) begin
      sat = sfc_pkg::OUT_MIN;
    end else begin
      sat = sfc_pkg::SAMPLE_W'(rsh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      plo <= acc[LO_W-1:0] * gain;
      phi <= $signed(acc[ACC_W-1:LO_W]) * $signed({1'b0, gain});
    end
    if (v1) begin
      rsh <= RS_W'(vsum >>> sfc_pkg::ROUND_SH);
    end
    if (v2) begin
      res <= sat;
    end
  end

endmodule

// ===== hdl/stereo_fir_convolver.sv =====
// stereo fir convolver top level: control, delay and tap memories, mac lanes
// a sample word runs its n taps in use through the macs, then the gain scaling
// one tap per cycle through the tap and delay rams
// items stall until the result is put out; a coefficient load word gives no result
// reset sets control and config; the delay line reads as zero by a fill count
// tap memories hold nothing defined until loaded
module stereo_fir_convolver #(
  parameter int MAX_TAPS = sfc_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                op,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [sfc_pkg::TAP_IDX_W-1:0]       tap_index,
  input  logic                                channel,
  input  logic signed [sfc_pkg::COEF_W-1:0]   coef_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [sfc_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sfc_pkg::SAMPLE_W-1:0] right_out
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = sfc_pkg::SAMPLE_W + sfc_pkg::COEF_W + AW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_SCALE,
    S_HOLD
  } state_t;

  state_t                       state;
  logic [sfc_pkg::TIU_W-1:0]    taps_in_use;
  logic                         stereo_mode;
  logic [sfc_pkg::GAIN_W-1:0]   gain;
  logic [AW-1:0]                wp;
  logic [AW-1:0]                wp_next;
  logic [CW-1:0]                fill;
  logic [CW-1:0]                fill_next;
  logic [AW-1:0]                pos;
  logic [AW-1:0]                pos_next;
  logic [AW-1:0]                k;
  logic [AW-1:0]                nm1;
  logic [CW-1:0]                n_eff;
  sfc_pkg::mac_ctl_t            p1;
  logic                         p1_mask;

  logic                         item_acc;
  logic                         is_sample;
  logic                         tap_ok;
  logic                         out_free;
  logic                         start;

  logic signed [sfc_pkg::SAMPLE_W-1:0] dl_rdata;
  logic signed [sfc_pkg::COEF_W-1:0]   lt_rdata;
  logic signed [sfc_pkg::COEF_W-1:0]   rt_rdata;
  logic signed [sfc_pkg::SAMPLE_W-1:0] x_eff;
  logic signed [ACC_W-1:0]             acc_l;
  logic signed [ACC_W-1:0]             acc_r;
  logic                                mac_done_l;
  logic                                mac_done_r;
  logic signed [sfc_pkg::SAMPLE_W-1:0] res_l;
  logic signed [sfc_pkg::SAMPLE_W-1:0] res_r;
  logic                                sc_done_l;
  logic                                sc_done_r;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign is_sample  = (op == sfc_pkg::OP_SAMPLE);
  assign start      = item_acc && is_sample;
  assign tap_ok     = 32'(tap_index) < MAX_TAPS;
  assign out_free   = !result_valid || !result_stall;

  assign wp_next   = (32'(wp) == MAX_TAPS - 1) ? '0 : wp + AW'(1);
  assign pos_next  = (pos == '0) ? AW'(MAX_TAPS - 1) : pos - AW'(1);
  assign fill_next = (32'(fill) == MAX_TAPS) ? fill : fill + CW'(1);

  always_comb begin
    if (taps_in_use == '0) begin
      n_eff = CW'(1);
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      n_eff = CW'(MAX_TAPS);
    end else begin
      n_eff = CW'(taps_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      wp           <= '0;
      fill         <= '0;
      taps_in_use  <= sfc_pkg::TIU_RESET;
      stereo_mode  <= 1'b0;
      gain         <= sfc_pkg::GAIN_RESET;
      p1           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfc_pkg::CFG_TAPS_IN_USE: taps_in_use <= sfc_pkg::TIU_W'(cfg_data);
          sfc_pkg::CFG_STEREO_MODE: stereo_mode <= cfg_data[0];
          sfc_pkg::CFG_GAIN:        gain        <= cfg_data;
          default: ;
        endcase
      end
      p1.valid <= (state == S_ISSUE);
      p1.last  <= (state == S_ISSUE) && (k == nm1);
      if (state == S_HOLD && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            wp    <= wp_next;
            fill  <= fill_next;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (k == nm1) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mac_done_l && mac_done_r) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (sc_done_l && sc_done_r) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pos <= wp;
      k   <= '0;
      nm1 <= AW'(n_eff - CW'(1));
    end else if (state == S_ISSUE) begin
      pos <= pos_next;
      k   <= k + AW'(1);
    end
    p1_mask <= CW'(pos) < fill;
    if (state == S_HOLD && out_free) begin
      left_out  <= res_l;
      right_out <= stereo_mode ? res_r : res_l;
    end
  end

  sfc_ram #(.WIDTH(sfc_pkg::SAMPLE_W), .DEPTH(MAX_TAPS)) u_delay (
    .clk   (clk),
    .we    (start),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (pos),
    .rdata (dl_rdata)
  );

  sfc_ram #(.WIDTH(sfc_pkg::COEF_W), .DEPTH(MAX_TAPS)) u_left_taps (
    .clk   (clk),
    .we    (item_acc && !is_sample && tap_ok && channel == sfc_pkg::CH_LEFT),
    .waddr (AW'(tap_index)),
    .wdata (coef_value),
    .raddr (k),
    .rdata (lt_rdata)
  );

  sfc_ram #(.WIDTH(sfc_pkg::COEF_W), .DEPTH(MAX_TAPS)) u_right_taps (
    .clk   (clk),
    .we    (item_acc && !is_sample && tap_ok && channel == sfc_pkg::CH_RIGHT),
    .waddr (AW'(tap_index)),
    .wdata (coef_value),
    .raddr (k),
    .rdata (rt_rdata)
  );

  // slots not yet written since reset read as zero
  assign x_eff = p1_mask ? dl_rdata : '0;

  sfc_mac #(.ACC_W(ACC_W)) u_mac_l (
    .clk   (clk),
    .rst   (rst),
    .clear (start),
    .ctl   (p1),
    .x     (x_eff),
    .tap   (lt_rdata),
    .acc   (acc_l),
    .done  (mac_done_l)
  );

  sfc_mac #(.ACC_W(ACC_W)) u_mac_r (
    .clk   (clk),
    .rst   (rst),
    .clear (start),
    .ctl   (p1),
    .x     (x_eff),
    .tap   (rt_rdata),
    .acc   (acc_r),
    .done  (mac_done_r)
  );

  sfc_scale #(.ACC_W(ACC_W)) u_scale_l (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_WAIT && mac_done_l),
    .acc   (acc_l),
    .gain  (gain),
    .res   (res_l),
    .done  (sc_done_l)
  );

  sfc_scale #(.ACC_W(ACC_W)) u_scale_r (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_WAIT && mac_done_r),
    .acc   (acc_r),
    .gain  (gain),
    .res   (res_r),
    .done  (sc_done_r)
  );

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    32'(wp) < MAX_TAPS)
    else $error("write pointer out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= MAX_TAPS)
    else $error("fill count above depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |-> k <= nm1)
    else $error("tap counter ran past last tap");

  a_mac_done_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done_l |-> state == S_WAIT && mac_done_r)
    else $error("accumulation finished outside wait");

  a_scale_done: assert property (@(posedge clk) disable iff (rst)
    sc_done_l |-> state == S_SCALE && sc_done_r)
    else $error("scaling finished outside scale state");

endmodule
